// ===== hdl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Types, codes and default sizes shared by the circular deque modules.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEFAULT_DEPTH      = 8;
    localparam int DEFAULT_DATA_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5,
        OP_DUMP       = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_DUMP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic  push;
        logic  pop;
        logic  rd_en;
        logic  front;
        logic  dump_start;
        logic  dump_step;
        logic  out_load;
        stat_t out_status;
        logic  out_rdata;
    } cdq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic walk_last;
    } cdq_flags_t;

endpackage

// ===== hdl/cdq_channels.sv =====
// ----------------------------------------------------------------------------
// cdq channels
// Valid/ready channel interfaces for deque requests and results.
// ----------------------------------------------------------------------------
interface cdq_in_if;
    import cdq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cdq_out_if;
    import cdq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] data;
    logic                      last;
    logic [OCC_W-1:0]          occupancy;

    modport source (output valid, output status, output data, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input data, input last,
                    input occupancy, output ready);
endinterface

// ===== hdl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Request decode and result sequencing for the circular deque.
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [cdq_pkg::OP_W-1:0]   in_operation,
    output logic                       in_ready,
    output logic                       out_valid,
    output logic                       out_last,
    input  logic                       out_ready,
    input  cdq_pkg::cdq_flags_t        flags,
    output cdq_pkg::cdq_cmd_t          cmd
);
    import cdq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        out_last   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = STAT_OK;
                    state_next     = ST_EMIT;
                    case (op_t'(in_operation))
                        OP_PUSH_FRONT, OP_PUSH_REAR:
                        begin
                            if (flags.full)
                            begin
                                cmd.out_status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push  = 1'b1;
                                cmd.front = (op_t'(in_operation) == OP_PUSH_FRONT);
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR:
                        begin
                            if (flags.empty)
                            begin
                                cmd.out_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.pop       = 1'b1;
                                cmd.rd_en     = 1'b1;
                                cmd.out_rdata = 1'b1;
                                cmd.front     = (op_t'(in_operation) == OP_POP_FRONT);
                            end
                        end
                        OP_PEEK_FRONT, OP_PEEK_REAR:
                        begin
                            if (flags.empty)
                            begin
                                cmd.out_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_en     = 1'b1;
                                cmd.out_rdata = 1'b1;
                                cmd.front     = (op_t'(in_operation) == OP_PEEK_FRONT);
                            end
                        end
                        OP_DUMP:
                        begin
                            if (flags.empty)
                            begin
                                cmd.out_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.dump_start = 1'b1;
                                cmd.rd_en      = 1'b1;
                                cmd.front      = 1'b1;
                                cmd.out_rdata  = 1'b1;
                                state_next     = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            // unused code: plain ok, no data
                            cmd.out_status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                out_last  = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                out_valid = 1'b1;
                out_last  = flags.walk_last;
                if (out_ready)
                begin
                    if (flags.walk_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // fetch next element while this one leaves
                        cmd.dump_step = 1'b1;
                        cmd.rd_en     = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/cdq_datapath.sv =====
// ----------------------------------------------------------------------------
// cdq_datapath
// Slot memory, front/rear indices, element count and result registers.
// ----------------------------------------------------------------------------
module cdq_datapath #(
    parameter int DEPTH      = cdq_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = cdq_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cdq_pkg::cdq_cmd_t                  cmd,
    input  logic signed [cdq_pkg::VALUE_W-1:0] value,
    output cdq_pkg::cdq_flags_t                flags,
    output logic [cdq_pkg::STATUS_W-1:0]       status,
    output logic signed [cdq_pkg::VALUE_W-1:0] data,
    output logic [cdq_pkg::OCC_W-1:0]          occupancy
);
    import cdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [IDX_W-1:0]      walk_reg, walk_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      remain_reg, remain_next;
    stat_t                 status_reg;
    logic                  rdata_sel_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      rd_addr;
    logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
    logic [DATA_WIDTH+VALUE_W-1:0] rdata_ext;
    logic [CNT_W+OCC_W-1:0]        count_ext;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - IDX_W'(1);
    endfunction

    assign flags.empty     = (count_reg == '0);
    assign flags.full      = (count_reg == CNT_FULL);
    assign flags.walk_last = (remain_reg == CNT_ONE);

    assign value_ext = {{DATA_WIDTH{1'b0}}, value};
    assign rdata_ext = {{VALUE_W{1'b0}}, rdata_reg};
    assign count_ext = {{OCC_W{1'b0}}, count_reg};

    assign status    = status_reg;
    assign data      = rdata_sel_reg ? rdata_ext[VALUE_W-1:0] : '0;
    assign occupancy = count_ext[OCC_W-1:0];

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        walk_next   = walk_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;

        if (cmd.dump_step)
        begin
            rd_addr = walk_reg;
        end
        else if (cmd.front)
        begin
            rd_addr = head_reg;
        end
        else
        begin
            rd_addr = tail_reg;
        end

        if (cmd.push)
        begin
            wr_en      = 1'b1;
            count_next = count_reg + CNT_ONE;
            if (flags.empty)
            begin
                head_next = '0;
                tail_next = '0;
                wr_addr   = '0;
            end
            else if (cmd.front)
            begin
                head_next = idx_dec(head_reg);
                wr_addr   = idx_dec(head_reg);
            end
            else
            begin
                tail_next = idx_inc(tail_reg);
                wr_addr   = idx_inc(tail_reg);
            end
        end

        if (cmd.pop)
        begin
            count_next = count_reg - CNT_ONE;
            if (count_reg == CNT_ONE)
            begin
                head_next = '0;
                tail_next = '0;
            end
            else if (cmd.front)
            begin
                head_next = idx_inc(head_reg);
            end
            else
            begin
                tail_next = idx_dec(tail_reg);
            end
        end

        if (cmd.dump_start)
        begin
            walk_next   = idx_inc(head_reg);
            remain_next = count_reg;
        end
        else if (cmd.dump_step)
        begin
            walk_next   = idx_inc(walk_reg);
            remain_next = remain_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            walk_reg      <= '0;
            count_reg     <= '0;
            remain_reg    <= '0;
            status_reg    <= STAT_OK;
            rdata_sel_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            walk_reg   <= walk_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            if (cmd.out_load)
            begin
                status_reg    <= cmd.out_status;
                rdata_sel_reg <= cmd.out_rdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value_ext[DATA_WIDTH-1:0];
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/circular_deque_core.sv =====
// ----------------------------------------------------------------------------
// circular_deque_core
// Fixed-depth ring-buffer double-ended queue with dump.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request: operation (push front/rear, pop front/rear,
//   peek front/rear, dump) and value, used by pushes only.
//   out_ch returns results: status (ok, overflow, empty), data, last, and
//   the occupancy after the operation. Every request gives one result with
//   last set, except a dump of a non-empty queue, which gives one result per
//   stored element, front to rear, with last on the rear one.
// Timing:
//   A request is taken while idle; its result is valid the next cycle, as
//   the status and the data come from registers, the data from a registered
//   read of the single slot memory. During a dump the next element is read
//   as each result is taken. The controller holds one request at a
//   time: in_ch.ready is low while results are pending.
// Reset: the queue comes up empty, no result pending; slot contents are not
//   cleared. A stalled receiver holds the current result and all state.
// ----------------------------------------------------------------------------
module circular_deque_core #(
    parameter int DEPTH      = cdq_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = cdq_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    cdq_in_if.sink    in_ch,
    cdq_out_if.source out_ch
);
    import cdq_pkg::*;

    cdq_cmd_t   cmd;
    cdq_flags_t flags;

    cdq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_operation (in_ch.operation),
        .in_ready     (in_ch.ready),
        .out_valid    (out_ch.valid),
        .out_last     (out_ch.last),
        .out_ready    (out_ch.ready),
        .flags        (flags),
        .cmd          (cmd)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (in_ch.value),
        .flags     (flags),
        .status    (out_ch.status),
        .data      (out_ch.data),
        .occupancy (out_ch.occupancy)
    );

endmodule

// ===== hdl/cdq_checker.sv =====
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks for circular_deque_core, attached by bind.
// ----------------------------------------------------------------------------
module cdq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [cdq_pkg::STATUS_W-1:0] status,
    input logic [cdq_pkg::VALUE_W-1:0]  data,
    input logic                       last,
    input logic [cdq_pkg::OCC_W-1:0]  occupancy
);
    import cdq_pkg::*;

    // a pending result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one request at a time: no new request while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken while results pending");

    // a dump does not change the queue between its results
    a_dump_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && occupancy == $past(occupancy))
        else $error("occupancy moved inside a dump");

    // empty report: nothing stored, no data, single result
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_EMPTY |-> occupancy == '0 && data == '0 && last)
        else $error("bad empty report");

    // a request is always answered right after it is taken
    a_answer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("request not answered");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (out_ch.status),
    .data      (out_ch.data),
    .last      (out_ch.last),
    .occupancy (out_ch.occupancy)
);
